// File: src/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared widths, defaults and types for the stream byte reassembler.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int INDEX_BITS_DEF = 32;

    localparam int IN_INDEX_W = 32;
    localparam int BYTE_W     = 8;
    localparam int HELD_W     = 7;
    localparam int PEND_W     = 7;

    typedef struct packed {
        logic store;
        logic at_head;
    } admit_t;

endpackage

// File: src/srb_byte_mem.sv
// ----------------------------------------------------------------------------
// srb_byte_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srb_byte_mem
    import srb_pkg::*;
#(
    parameter int DEPTH  = CAPACITY_DEF,
    parameter int ADDR_W = $clog2(CAPACITY_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/srb_admit.sv
// ----------------------------------------------------------------------------
// srb_admit
// Window check for one incoming transaction: store decision and ring slot.
// ----------------------------------------------------------------------------
module srb_admit
    import srb_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic [INDEX_BITS-1:0]       idx,
    input  logic                        has_byte,
    input  logic [HELD_W-1:0]           reader_buffered,
    input  logic [INDEX_BITS-1:0]       next_expected,
    input  logic                        closed,
    input  logic [$clog2(CAPACITY)-1:0] head,
    output admit_t                      decision,
    output logic [$clog2(CAPACITY)-1:0] slot
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int SUM_W  = SLOT_W + 1;

    logic [HELD_W-1:0]     limit;
    logic [INDEX_BITS-1:0] offset;
    logic [SUM_W-1:0]      sum;

    always_comb
    begin
        limit  = (reader_buffered < HELD_W'(CAPACITY)) ?
                 HELD_W'(CAPACITY) - reader_buffered : '0;
        offset = idx - next_expected;
        decision.store   = has_byte && !closed && (idx >= next_expected) &&
                           (offset < INDEX_BITS'(limit));
        decision.at_head = (offset == '0);
        sum = SUM_W'(head) + SUM_W'(offset[SLOT_W-1:0]);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        slot = sum[SLOT_W-1:0];
    end

endmodule

// File: src/stream_byte_reassembler_top.sv
// Flow: a transaction that releases nothing passes through ST_STATUS, which registers its
//   status result; one that releases a run goes to ST_EMIT, through ST_SCAN when more bytes follow.
// Throughput: ST_SCAN checks the valid marks one mark a cycle, and ST_EMIT streams the run
//   out of the byte store port, holding while out_stall is high; in_stall holds new input until idle.
// Reset: asynchronous, clears control state and valid marks at once; byte store
//   contents stay undefined until written, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// stream_byte_reassembler_top
// Out-of-order byte reassembly over a ring store with in-order release.
// ----------------------------------------------------------------------------
module stream_byte_reassembler_top
    import srb_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_INDEX_W-1:0] stream_index,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  has_byte,
    input  logic                  ends_stream,
    input  logic [HELD_W-1:0]     reader_buffered,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  byte_valid,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  run_last,
    output logic                  stream_closed,
    output logic [PEND_W-1:0]     pending_count
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATUS,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [INDEX_BITS-1:0] ne_reg, ne_next;
    logic [INDEX_BITS-1:0] end_reg, end_next;
    logic                  end_known_reg, end_known_next;
    logic                  closed_reg, closed_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]      pend_reg, pend_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  byte_valid_reg, byte_valid_next;
    logic                  run_last_reg, run_last_next;
    logic                  closed_out_reg, closed_out_next;
    logic [CNT_W-1:0]      pend_out_reg, pend_out_next;

    logic [INDEX_BITS-1:0] idx;
    admit_t                decision;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W-1:0]     head_inc;
    logic                  in_acc;
    logic                  out_free;
    logic                  mem_we;
    logic                  mem_re;
    logic [BYTE_W-1:0]     mem_rdata;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
        return (p == SLOT_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    assign idx      = INDEX_BITS'(stream_index);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign head_inc = slot_inc(head_reg);

    srb_admit #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_admit (
        .idx             (idx),
        .has_byte        (has_byte),
        .reader_buffered (reader_buffered),
        .next_expected   (ne_reg),
        .closed          (closed_reg),
        .head            (head_reg),
        .decision        (decision),
        .slot            (slot)
    );

    srb_byte_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot),
        .wdata (data_byte),
        .re    (mem_re),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        ne_next         = ne_reg;
        end_next        = end_reg;
        end_known_next  = end_known_reg;
        closed_next     = closed_reg;
        head_next       = head_reg;
        ptr_next        = ptr_reg;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        byte_valid_next = byte_valid_reg;
        run_last_next   = run_last_reg;
        closed_out_next = closed_out_reg;
        pend_out_next   = pend_out_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (ends_stream)
                    begin
                        end_next       = idx + INDEX_BITS'(has_byte);
                        end_known_next = 1'b1;
                    end
                    if (decision.store)
                    begin
                        mem_we           = 1'b1;
                        valid_next[slot] = 1'b1;
                        pend_next        = pend_reg + CNT_W'(!valid_reg[slot]);
                    end
                    if (decision.store && decision.at_head)
                    begin
                        if (valid_reg[head_inc])
                        begin
                            cnt_next   = CNT_W'(2);
                            ptr_next   = slot_inc(head_inc);
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            cnt_next    = CNT_W'(1);
                            pend_next   = pend_next - CNT_W'(1);
                            closed_next = closed_reg ||
                                          (end_known_next &&
                                           (ne_reg + INDEX_BITS'(1) == end_next));
                            state_next  = ST_EMIT;
                        end
                    end
                    else
                    begin
                        closed_next = closed_reg || (end_known_next && (ne_reg == end_next));
                        state_next  = ST_STATUS;
                    end
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    byte_valid_next = 1'b0;
                    run_last_next   = 1'b1;
                    closed_out_next = closed_reg;
                    pend_out_next   = pend_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg < CNT_W'(CAPACITY)) && valid_reg[ptr_reg])
                begin
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = slot_inc(ptr_reg);
                end
                else
                begin
                    pend_next   = pend_reg - cnt_reg;
                    closed_next = closed_reg ||
                                  (end_known_reg &&
                                   (ne_reg + INDEX_BITS'(cnt_reg) == end_reg));
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    mem_re               = 1'b1;
                    valid_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    ne_next              = ne_reg + 1'b1;
                    cnt_next             = cnt_reg - 1'b1;
                    out_valid_next       = 1'b1;
                    byte_valid_next      = 1'b1;
                    run_last_next        = (cnt_reg == CNT_W'(1));
                    closed_out_next      = closed_reg;
                    pend_out_next        = pend_reg;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ne_reg         <= '0;
            end_reg        <= '0;
            end_known_reg  <= 1'b0;
            closed_reg     <= 1'b0;
            head_reg       <= '0;
            ptr_reg        <= '0;
            valid_reg      <= '0;
            pend_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            byte_valid_reg <= 1'b0;
            run_last_reg   <= 1'b0;
            closed_out_reg <= 1'b0;
            pend_out_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ne_reg         <= ne_next;
            end_reg        <= end_next;
            end_known_reg  <= end_known_next;
            closed_reg     <= closed_next;
            head_reg       <= head_next;
            ptr_reg        <= ptr_next;
            valid_reg      <= valid_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            byte_valid_reg <= byte_valid_next;
            run_last_reg   <= run_last_next;
            closed_out_reg <= closed_out_next;
            pend_out_reg   <= pend_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_valid    = byte_valid_reg;
    assign out_byte      = byte_valid_reg ? mem_rdata : '0;
    assign run_last      = run_last_reg;
    assign stream_closed = closed_out_reg;
    assign pending_count = PEND_W'(pend_out_reg);

    a_emit_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> valid_reg[head_reg])
        else $error("emitting from an empty slot");

    a_idle_head_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !valid_reg[head_reg])
        else $error("stored byte left at head while idle");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("emit with zero run length");

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag dropped");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(CAPACITY))
        else $error("pending count over capacity");

endmodule
